### rtl/saturating_rgb_image_store_defines.svh
// Assertion macros shared by the frame store RTL
`ifndef SATURATING_RGB_IMAGE_STORE_DEFINES_SVH
`define SATURATING_RGB_IMAGE_STORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Condition must never be true
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/srgb_pkg.sv
// Types and constants of the saturating RGB frame store
`default_nettype none

package srgb_pkg;

    localparam int COMP_W = 12;
    localparam int OPND_W = 13;
    localparam int IDX_W  = 8;
    localparam int OP_W   = 3;

    localparam logic [COMP_W-1:0] MAX_LEVEL_RESET = 12'd1000;

    // Operation codes; codes without a member act as read
    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_ADD   = 3'd2,
        OP_SUB   = 3'd3,
        OP_FILL  = 3'd4
    } t_op;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        t_pixel pix;
        logic   was_clipped;
        logic   index_ok;
    } t_result;

endpackage

`default_nettype wire

### rtl/srgb_if.sv
// Request and result channel interfaces of the frame store
`default_nettype none

interface srgb_req_if import srgb_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [OPND_W-1:0] red_in;
    logic signed [OPND_W-1:0] green_in;
    logic signed [OPND_W-1:0] blue_in;

    modport source (
        output valid, op, row_index, col_index, red_in, green_in, blue_in,
        input  ready
    );
    modport sink (
        input  valid, op, row_index, col_index, red_in, green_in, blue_in,
        output ready
    );
endinterface

interface srgb_rsp_if import srgb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [COMP_W-1:0] red_out;
    logic [COMP_W-1:0] green_out;
    logic [COMP_W-1:0] blue_out;
    logic              was_clipped;
    logic              index_ok;

    modport source (
        output valid, red_out, green_out, blue_out, was_clipped, index_ok,
        input  ready
    );
    modport sink (
        input  valid, red_out, green_out, blue_out, was_clipped, index_ok,
        output ready
    );
endinterface

`default_nettype wire

### rtl/saturating_rgb_image_store.sv
// Saturating RGB frame store, top level
//
// Frame store of ROWS x COLS pixels held in one single-port-write,
// one-port-read synchronous memory. A pixel request is read at the edge it
// is accepted, then modified, clipped and written back from the work stage
// as its result is loaded into the output register, so pixel requests run
// at one per cycle while the result channel is not stalled; back-to-back
// requests to the same pixel see the previous write through a forwarding
// register. A fill request sweeps the memory one pixel per cycle and blocks
// new requests until the sweep is done. After reset the same sweep clears
// the store to black before the first request is accepted; writes of
// max_level are taken at any time.
`default_nettype none
`include "saturating_rgb_image_store_defines.svh"

module saturating_rgb_image_store import srgb_pkg::*; #(
    parameter int ROWS = 16,
    parameter int COLS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [COMP_W-1:0] i_cfg_wdata,
    srgb_req_if.sink          i_req,
    srgb_rsp_if.source        o_rsp
);

    localparam int DEPTH  = ROWS * COLS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FULL_W = 2 * IDX_W;

    // ---------------- configuration ----------------
    logic [COMP_W-1:0] r_max_level;

    // Hold max_level until written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_level <= MAX_LEVEL_RESET;
        end else if (i_cfg_we) begin
            r_max_level <= i_cfg_wdata;
        end
    end

    // ---------------- control signals ----------------
    logic                     r_s1_valid;
    t_op                      r_s1_op;
    logic                     r_s1_ok;
    logic [AW-1:0]            r_s1_addr;
    logic signed [OPND_W-1:0] r_s1_red;
    logic signed [OPND_W-1:0] r_s1_green;
    logic signed [OPND_W-1:0] r_s1_blue;

    logic                     r_sweep_active;
    logic [AW-1:0]            r_sweep_addr;
    t_pixel                   r_sweep_color;

    logic                     r_fwd_valid;
    logic [AW-1:0]            r_fwd_addr;
    t_pixel                   r_fwd_data;

    logic                     r_out_valid;
    t_result                  r_out;

    logic                     req_fire;
    logic                     s1_adv;
    logic                     s1_wr_en;
    logic                     fill_done;

    // Advance the work stage when the output register is free or drained
    assign s1_adv    = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign fill_done = s1_adv && (r_s1_op == OP_FILL);

    // Take a request when the work stage is empty or advancing a non-fill request, never while sweeping
    assign i_req.ready = !r_sweep_active &&
                         (!r_s1_valid || (s1_adv && (r_s1_op != OP_FILL)));
    assign req_fire    = i_req.valid && i_req.ready;

    // ---------------- address decode ----------------
    logic              req_ok;
    logic [FULL_W-1:0] addr_full;
    logic [AW-1:0]     req_addr;

    assign req_ok    = ({1'b0, i_req.row_index} < (IDX_W+1)'(ROWS)) &&
                       ({1'b0, i_req.col_index} < (IDX_W+1)'(COLS));
    assign addr_full = {{IDX_W{1'b0}}, i_req.row_index} * FULL_W'(COLS) +
                       {{IDX_W{1'b0}}, i_req.col_index};
    assign req_addr  = req_ok ? addr_full[AW-1:0] : '0;

    // ---------------- work stage registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (req_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Capture the request payload
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_s1_op    <= t_op'(i_req.op);
            r_s1_ok    <= req_ok;
            r_s1_addr  <= req_addr;
            r_s1_red   <= i_req.red_in;
            r_s1_green <= i_req.green_in;
            r_s1_blue  <= i_req.blue_in;
        end
    end

    // ---------------- pixel memory ----------------
    t_pixel        r_mem [DEPTH];
    t_pixel        r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_pixel        mem_wdata;
    t_pixel        new_pix;

    assign mem_we    = r_sweep_active || s1_wr_en;
    assign mem_waddr = r_sweep_active ? r_sweep_addr : r_s1_addr;
    assign mem_wdata = r_sweep_active ? r_sweep_color : new_pix;

    // Write one pixel, read one pixel at request acceptance
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (req_fire) begin
            r_rdata <= r_mem[req_addr];
        end
    end

    // ---------------- forwarding ----------------
    t_pixel cur_pix;

    // Track the latest pixel write; drop it once a sweep overwrites everything
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (r_sweep_active || fill_done) begin
            r_fwd_valid <= 1'b0;
        end else if (s1_wr_en) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_wr_en) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= new_pix;
        end
    end

    assign cur_pix = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : r_rdata;

    // ---------------- per-channel arithmetic ----------------
    logic clip_red;
    logic clip_green;
    logic clip_blue;
    logic any_clip;

    srgb_chan_alu u_alu_red (
        .i_op        (r_s1_op),
        .i_cur       (cur_pix.red),
        .i_opnd      (r_s1_red),
        .i_max_level (r_max_level),
        .o_value     (new_pix.red),
        .o_clipped   (clip_red)
    );

    srgb_chan_alu u_alu_green (
        .i_op        (r_s1_op),
        .i_cur       (cur_pix.green),
        .i_opnd      (r_s1_green),
        .i_max_level (r_max_level),
        .o_value     (new_pix.green),
        .o_clipped   (clip_green)
    );

    srgb_chan_alu u_alu_blue (
        .i_op        (r_s1_op),
        .i_cur       (cur_pix.blue),
        .i_opnd      (r_s1_blue),
        .i_max_level (r_max_level),
        .o_value     (new_pix.blue),
        .o_clipped   (clip_blue)
    );

    assign any_clip = clip_red || clip_green || clip_blue;

    // Write back only valid pixel writes, adds and subtracts
    always_comb begin
        case (r_s1_op)
            OP_WRITE, OP_ADD, OP_SUB: s1_wr_en = s1_adv && r_s1_ok;
            default:                  s1_wr_en = 1'b0;
        endcase
    end

    // ---------------- fill and reset sweep ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_active <= 1'b1;
            r_sweep_addr   <= '0;
            r_sweep_color  <= '0;
        end else if (fill_done) begin
            r_sweep_active <= 1'b1;
            r_sweep_addr   <= '0;
            r_sweep_color  <= new_pix;
        end else if (r_sweep_active) begin
            if (r_sweep_addr == AW'(DEPTH - 1)) begin
                r_sweep_active <= 1'b0;
            end else begin
                r_sweep_addr <= r_sweep_addr + 1'b1;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result; invalid pixel accesses report black and no clipping
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.index_ok <= r_s1_ok;
            if (r_s1_ok || (r_s1_op == OP_FILL)) begin
                r_out.pix         <= new_pix;
                r_out.was_clipped <= any_clip;
            end else begin
                r_out.pix         <= '0;
                r_out.was_clipped <= 1'b0;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.red_out     = r_out.pix.red;
    assign o_rsp.green_out   = r_out.pix.green;
    assign o_rsp.blue_out    = r_out.pix.blue;
    assign o_rsp.was_clipped = r_out.was_clipped;
    assign o_rsp.index_ok    = r_out.index_ok;

    // ---------------- assertions ----------------
    `ASSERT_NEVER(a_sweep_stage_overlap, i_clk, i_rst_n, r_sweep_active && r_s1_valid, "sweep overlaps a pending request")
    `ASSERT_IMPLY(a_sweep_blocks_req, i_clk, i_rst_n, r_sweep_active, !i_req.ready, "request taken during sweep")
    `ASSERT_NEXT(a_fill_starts_sweep, i_clk, i_rst_n, fill_done, r_sweep_active && (r_sweep_addr == '0), "fill did not start a sweep")
    `ASSERT_IMPLY(a_write_needs_index, i_clk, i_rst_n, s1_wr_en, r_s1_ok && !r_sweep_active, "write-back with bad index or during sweep")

endmodule

`default_nettype wire

### rtl/srgb_chan_alu.sv
// One colour channel: apply the operation and clip to the configured level
`default_nettype none

module srgb_chan_alu import srgb_pkg::*; (
    input  t_op                      i_op,
    input  logic [COMP_W-1:0]        i_cur,
    input  logic signed [OPND_W-1:0] i_opnd,
    input  logic [COMP_W-1:0]        i_max_level,
    output logic [COMP_W-1:0]        o_value,
    output logic                     o_clipped
);

    localparam int SUM_W = COMP_W + 3;

    logic signed [SUM_W-1:0] cur_ext;
    logic signed [SUM_W-1:0] opnd_ext;
    logic signed [SUM_W-1:0] v;

    assign cur_ext  = $signed({3'b000, i_cur});
    assign opnd_ext = $signed({{(SUM_W-OPND_W){i_opnd[OPND_W-1]}}, i_opnd});

    // Select the raw result of the operation
    always_comb begin
        case (i_op)
            OP_WRITE: v = opnd_ext;
            OP_FILL:  v = opnd_ext;
            OP_ADD:   v = cur_ext + opnd_ext;
            OP_SUB:   v = cur_ext - opnd_ext;
            default:  v = cur_ext;
        endcase
    end

    // Clip to zero and to the maximum level
    always_comb begin
        if (v[SUM_W-1]) begin
            o_value   = '0;
            o_clipped = 1'b1;
        end else if (v[SUM_W-2:0] > {2'b00, i_max_level}) begin
            o_value   = i_max_level;
            o_clipped = 1'b1;
        end else begin
            o_value   = v[COMP_W-1:0];
            o_clipped = 1'b0;
        end
    end

endmodule

`default_nettype wire
